[rtl/assert_macros.svh]
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/ksc_pkg.sv]
// types and constants of the k-combination subset sum counter
package ksc_pkg;

  // field widths
  localparam int ELEM_W     = 16;
  localparam int TAKE_K_W   = 6;
  localparam int TARGET_W   = 21;
  localparam int COUNT_W    = 30;
  localparam int LEN_W      = 6;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 21;

  // saturation value of the match count
  localparam logic [COUNT_W-1:0] COUNT_CAP = {COUNT_W{1'b1}};

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAKE_K     = 1'b0,
    REG_TARGET_SUM = 1'b1
  } ksc_reg_t;

  // controller states
  typedef enum logic [2:0] {
    S_LOAD,
    S_START,
    S_WALK,
    S_DRAIN,
    S_RESULT
  } ksc_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic in_ready;
    logic load_en;
    logic start;
    logic step_en;
    logic result_load;
  } ksc_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic in_valid;
    logic in_last;
    logic skip;
    logic issue_done;
    logic pipe_empty;
    logic out_free;
  } ksc_status_t;

endpackage

[rtl/ksc_intf.sv]
// channel interfaces: element input, result output, configuration write

// element input channel
interface ksc_in_if import ksc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [ELEM_W-1:0] element_value;
  logic                     last_element;

  modport source (output valid, output element_value, output last_element, input ready);
  modport sink   (input valid, input element_value, input last_element, output ready);
endinterface

// result output channel
interface ksc_out_if import ksc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] match_count;
  logic [LEN_W-1:0]   list_length;

  modport source (output valid, output match_count, output list_length, input ready);
  modport sink   (input valid, input match_count, input list_length, output ready);
endinterface

// configuration write channel
interface ksc_cfg_if import ksc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  reg_index;
  logic [CFG_DATA_W-1:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink   (input valid, input reg_index, input wr_data, output ready);
endinterface

[rtl/k_subset_sum_counter_top.sv]
// k-combination subset sum counter, top level
//
// in_ch carries one list element per transaction (element_value, last_element).
// Elements load into the store at one per cycle; beyond MAX_N they are dropped.
// The transaction with last_element set starts the count: every non-empty subset of the
// n loaded elements is visited in gray-code order, one subset per cycle, and
// those with k members summing to target_sum are counted (saturating).
// The sum loop flips a single bit per subset and reads one store entry per
// cycle; if k is zero or larger than n the walk is skipped and the count is 0.
// in_ch is not ready from the last element until the result has moved to the
// output register. out_ch then holds match_count and list_length until taken;
// a stalled receiver blocks only the next list's result, not its loading.
// cfg_ch writes take_k (index 0) and target_sum (index 1) and is always ready;
// write it only while the block is idle.
// rst_n (synchronous) empties the store and output, take_k = 1, target_sum = 0.

module k_subset_sum_counter_top import ksc_pkg::*; #(
  parameter int MAX_N = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  ksc_in_if.sink    in_ch,
  ksc_out_if.source out_ch,
  ksc_cfg_if.sink   cfg_ch
);

  ksc_cmd_t    cmd;
  ksc_status_t status;

  // controller
  ksc_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .status (status),
    .cmd    (cmd)
  );

  // datapath
  ksc_datapath #(
    .MAX_N (MAX_N)
  ) u_datapath (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch),
    .cmd    (cmd),
    .status (status)
  );

endmodule

[rtl/ksc_ctrl.sv]
// controller state machine: load, walk, drain and result hand-off
`include "assert_macros.svh"

module ksc_ctrl import ksc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  ksc_status_t status,
  output ksc_cmd_t    cmd
);

  ksc_state_t state_r;
  ksc_state_t state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_LOAD: begin
        cmd.in_ready = 1'b1;
        cmd.load_en  = status.in_valid;
        if (status.in_valid && status.in_last) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        cmd.start = 1'b1;
        state_nxt = status.skip ? S_RESULT : S_WALK;
      end
      S_WALK: begin
        if (!status.issue_done) begin
          cmd.step_en = 1'b1;
        end else begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        if (status.pipe_empty) begin
          state_nxt = S_RESULT;
        end
      end
      S_RESULT: begin
        if (status.out_free) begin
          cmd.result_load = 1'b1;
          state_nxt       = S_LOAD;
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  // checks
  `ASSERT_ALWAYS(a_result_slot_free, clk, rst_n, !cmd.result_load || status.out_free,
                 "result loaded while output register still occupied")
  `ASSERT_ALWAYS(a_no_step_past_end, clk, rst_n, !cmd.step_en || !status.issue_done,
                 "walk step issued after the last subset")

endmodule

[rtl/ksc_datapath.sv]
// datapath: element store, gray-code subset walk, sum pipeline, count and output register
`include "assert_macros.svh"

module ksc_datapath import ksc_pkg::*; #(
  parameter int MAX_N = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  ksc_in_if.sink      in_ch,
  ksc_out_if.source   out_ch,
  ksc_cfg_if.sink     cfg_ch,
  input  ksc_cmd_t    cmd,
  output ksc_status_t status
);

  localparam int IDXW  = $clog2(MAX_N);
  localparam int PW    = $clog2(MAX_N + 1);
  localparam int STEPW = MAX_N + 1;
  localparam int SW    = ELEM_W + $clog2(MAX_N) + 1;
  localparam int TW    = (SW > TARGET_W) ? SW : TARGET_W;
  localparam int CW    = (PW > TAKE_K_W) ? ((PW > LEN_W) ? PW : LEN_W)
                                         : ((TAKE_K_W > LEN_W) ? TAKE_K_W : LEN_W);

  // configuration registers
  logic [TAKE_K_W-1:0]        take_k_r;
  logic signed [TARGET_W-1:0] target_sum_r;

  // element store and fill count
  logic signed [ELEM_W-1:0] store_mem [MAX_N];
  logic [PW-1:0]            loaded_count_r;
  logic                     full;

  // walk state
  logic [STEPW-1:0] step_r;
  logic [STEPW-1:0] limit_r;
  logic [IDXW-1:0]  flip_idx;
  logic             flip_hi;

  // pipeline
  logic                     vld0_r, vld1_r, vld2_r, hit_r;
  logic [IDXW-1:0]          idx0_r;
  logic                     add0_r, add1_r;
  logic signed [ELEM_W-1:0] elem_r;
  logic signed [SW-1:0]     sum_r;
  logic [PW-1:0]            pop_r;
  logic [COUNT_W-1:0]       count_r;
  logic                     match;

  // output register
  logic               out_valid_r;
  logic [COUNT_W-1:0] match_count_r;
  logic [LEN_W-1:0]   list_length_r;
  logic [CW-1:0]      loaded_ext;
  logic [CW-1:0]      take_k_ext;

  assign full       = (loaded_count_r == PW'(MAX_N));
  assign loaded_ext = CW'(loaded_count_r);
  assign take_k_ext = CW'(take_k_r);

  // configuration writes, always accepted
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      take_k_r     <= TAKE_K_W'(1);
      target_sum_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (ksc_reg_t'(cfg_ch.reg_index))
        REG_TAKE_K:     take_k_r     <= cfg_ch.wr_data[TAKE_K_W-1:0];
        REG_TARGET_SUM: target_sum_r <= cfg_ch.wr_data[TARGET_W-1:0];
        default:        ;
      endcase
    end
  end

  // input channel
  assign in_ch.ready = cmd.in_ready;

  // element store write, elements past a full store are dropped
  always_ff @(posedge clk) begin
    if (cmd.load_en && !full) begin
      store_mem[loaded_count_r[IDXW-1:0]] <= in_ch.element_value;
    end
  end

  // fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_count_r <= '0;
    end else if (cmd.result_load) begin
      loaded_count_r <= '0;
    end else if (cmd.load_en && !full) begin
      loaded_count_r <= loaded_count_r + PW'(1);
    end
  end

  // lowest set bit of the step counter picks the gray-code bit to flip
  always_comb begin
    flip_idx = '0;
    flip_hi  = 1'b0;
    for (int b = MAX_N - 1; b >= 0; b--) begin
      if (step_r[b]) begin
        flip_idx = IDXW'(b);
        flip_hi  = step_r[b + 1];
      end
    end
  end

  // step counter runs from 1 up to 2^n
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r  <= '0;
      limit_r <= '0;
    end else if (cmd.start) begin
      step_r  <= STEPW'(1);
      limit_r <= STEPW'(1) << loaded_count_r;
    end else if (cmd.step_en) begin
      step_r <= step_r + STEPW'(1);
    end
  end

  // stage 0: flip position and direction (bit enters when the next higher bit is clear)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld0_r <= 1'b0;
    end else begin
      vld0_r <= cmd.step_en;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step_en) begin
      idx0_r <= flip_idx;
      add0_r <= !flip_hi;
    end
  end

  // stage 1: registered store read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld1_r <= 1'b0;
    end else begin
      vld1_r <= vld0_r;
    end
  end

  always_ff @(posedge clk) begin
    elem_r <= store_mem[idx0_r];
    add1_r <= add0_r;
  end

  // stage 2: running subset sum and size
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld2_r <= 1'b0;
      sum_r  <= '0;
      pop_r  <= '0;
    end else if (cmd.start) begin
      vld2_r <= 1'b0;
      sum_r  <= '0;
      pop_r  <= '0;
    end else begin
      vld2_r <= vld1_r;
      if (vld1_r) begin
        if (add1_r) begin
          sum_r <= sum_r + SW'(elem_r);
          pop_r <= pop_r + PW'(1);
        end else begin
          sum_r <= sum_r - SW'(elem_r);
          pop_r <= pop_r - PW'(1);
        end
      end
    end
  end

  // stage 3: compare against target and k
  assign match = (TW'(sum_r) == TW'(target_sum_r)) && (CW'(pop_r) == take_k_ext);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r <= 1'b0;
    end else begin
      hit_r <= vld2_r && match;
    end
  end

  // stage 4: saturating match count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.start) begin
      count_r <= '0;
    end else if (hit_r && (count_r != COUNT_CAP)) begin
      count_r <= count_r + COUNT_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.result_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.result_load) begin
      match_count_r <= count_r;
      list_length_r <= loaded_ext[LEN_W-1:0];
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.match_count = match_count_r;
  assign out_ch.list_length = list_length_r;

  // status to the controller
  assign status.in_valid   = in_ch.valid;
  assign status.in_last    = in_ch.last_element;
  assign status.skip       = (take_k_r == '0) || (take_k_ext > loaded_ext);
  assign status.issue_done = (step_r == limit_r);
  assign status.pipe_empty = !(vld0_r || vld1_r || vld2_r || hit_r);
  assign status.out_free   = !out_valid_r || out_ch.ready;

  // checks
  `ASSERT_NEXT(a_start_clears_count, clk, rst_n, cmd.start, count_r == '0,
               "match count not cleared at walk start")
  `ASSERT_NEXT(a_count_monotonic, clk, rst_n, !cmd.start, count_r >= $past(count_r),
               "match count went down during a walk")
  `ASSERT_ALWAYS(a_result_after_drain, clk, rst_n,
                 !cmd.result_load || status.pipe_empty,
                 "result taken while the sum pipeline still held subsets")

endmodule
